// ----- sv/pcrt_pkg.sv -----
`timescale 1ns / 1ps

package pcrt_pkg;

  localparam int unsigned SLOTS      = 8;
  localparam int unsigned SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned RETRY_W    = 8;
  localparam int unsigned INTERVAL_W = 10;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST     = TIMEOUT_W'(100);
  localparam logic [RETRY_W-1:0]    MAX_RETRIES_RST = RETRY_W'(3);
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST    = INTERVAL_W'(10);

  localparam logic EVENT_RESEND = 1'b0;
  localparam logic EVENT_ABORT  = 1'b1;
  localparam logic KIND_PARAM   = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ISSUE = 2'd0,
    FUNC_RESP  = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    REG_TIMEOUT        = 2'd0,
    REG_MAX_RETRIES    = 2'd1,
    REG_CHECK_INTERVAL = 2'd2
  } reg_e;

  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic [TIME_W-1:0] lim;
  } cmp_req_t;

  typedef struct packed {
    logic a_lt_b;
    logic below_lim;
  } cmp_rsp_t;

  typedef struct packed {
    logic              event_res;
    logic [ADDR_W-1:0] addr;
    logic              kind;
    logic [DATA_W-1:0] payload;
  } result_t;

endpackage

// ----- sv/pcrt_cmp_unit.sv -----
`timescale 1ns / 1ps

module pcrt_cmp_unit (
  input  pcrt_pkg::cmp_req_t req_i,
  output pcrt_pkg::cmp_rsp_t rsp_o
);

  logic [pcrt_pkg::TIME_W:0] sub;

  assign sub             = {1'b0, req_i.a} - {1'b0, req_i.b};
  assign rsp_o.a_lt_b    = sub[pcrt_pkg::TIME_W];
  assign rsp_o.below_lim = sub[pcrt_pkg::TIME_W-1:0] < req_i.lim;

endmodule

// ----- sv/pending_command_retry_tracker.sv -----
`timescale 1ns / 1ps

// Pending command retry tracker.
// Input channel (in_valid_i/in_ready_o) takes one word per command event:
// issue, response or a one-millisecond tick. Output channel
// (out_valid_o/out_ready_i) gives resend and session-abort words; last_o
// marks the final word of one tick. Registers timeout_ms, max_retries and
// check_interval sit on the APB port at 0x0, 0x4 and 0x8.
// A response is accepted, then visits one slot per cycle through the shared
// subtract/compare unit. A tick is checked against check_interval; when a
// scan is due it visits every slot, holding while the receiver stalls, and
// then flushes its last result word.
// in_ready_o is high only while no event is being worked on.
// Reset clears time, the scan mark and all slot valid bits, and loads the
// register defaults (100, 3, 10). A stalled receiver holds the output word;
// the scan holds on the next result that would need the output register.
module pending_command_retry_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pcrt_pkg::FUNC_W-1:0]         func_i,
  input  logic [pcrt_pkg::ADDR_W-1:0]         peer_addr_i,
  input  logic                                cmd_kind_i,
  input  logic [pcrt_pkg::DATA_W-1:0]         payload_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                event_res_o,
  output logic [pcrt_pkg::ADDR_W-1:0]         out_addr_o,
  output logic                                out_kind_o,
  output logic [pcrt_pkg::DATA_W-1:0]         out_payload_o,
  output logic                                last_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pcrt_pkg::PADDR_W-1:0]        paddr,
  input  logic [pcrt_pkg::PDATA_W-1:0]        pwdata,
  output logic [pcrt_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RESP  = 5'b00010,
    S_CHECK = 5'b00100,
    S_SCAN  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [pcrt_pkg::TIMEOUT_W-1:0]  timeout_q;
  logic [pcrt_pkg::RETRY_W-1:0]    max_retries_q;
  logic [pcrt_pkg::INTERVAL_W-1:0] interval_q;

  logic [pcrt_pkg::TIME_W-1:0] now_q;
  logic [pcrt_pkg::TIME_W-1:0] last_check_q;

  logic [pcrt_pkg::SLOTS-1:0]   waiting_q;
  logic [pcrt_pkg::TIME_W-1:0]  stamp_q   [pcrt_pkg::SLOTS];
  logic [pcrt_pkg::ADDR_W-1:0]  addr_q    [pcrt_pkg::SLOTS];
  logic                         kind_q    [pcrt_pkg::SLOTS];
  logic [pcrt_pkg::RETRY_W-1:0] retries_q [pcrt_pkg::SLOTS];
  logic [pcrt_pkg::DATA_W-1:0]  payload_q [pcrt_pkg::SLOTS];

  logic [pcrt_pkg::SLOT_W-1:0] idx_q;
  logic                        idx_last;

  logic [pcrt_pkg::ADDR_W-1:0] req_peer_q;
  logic                        req_kind_q;
  logic                        best_v_q;
  logic [pcrt_pkg::SLOT_W-1:0] best_idx_q;
  logic [pcrt_pkg::TIME_W-1:0] best_stamp_q;

  pcrt_pkg::result_t pend_q, out_q, new_res;
  logic              pend_v_q;
  logic              out_valid_q;
  logic              out_last_q;
  logic              out_load;

  logic                        in_acc;
  logic                        cfg_wr;
  logic [pcrt_pkg::SLOT_W-1:0] free_idx;
  logic                        free_found;

  pcrt_pkg::cmp_req_t cmp_req;
  pcrt_pkg::cmp_rsp_t cmp_rsp;

  logic resp_match;
  logic resp_take;
  logic scan_expired;
  logic scan_retry;
  logic scan_emit;
  logic out_free;
  logic scan_step;

  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign idx_last   = (idx_q == pcrt_pkg::SLOT_W'(pcrt_pkg::SLOTS - 1));
  assign out_free   = !out_valid_q || out_ready_i;

  // APB registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q     <= pcrt_pkg::TIMEOUT_RST;
      max_retries_q <= pcrt_pkg::MAX_RETRIES_RST;
      interval_q    <= pcrt_pkg::INTERVAL_RST;
    end else if (cfg_wr) begin
      case (pcrt_pkg::reg_e'(paddr[3:2]))
        pcrt_pkg::REG_TIMEOUT: begin
          timeout_q <= pwdata[pcrt_pkg::TIMEOUT_W-1:0];
        end
        pcrt_pkg::REG_MAX_RETRIES: begin
          max_retries_q <= pwdata[pcrt_pkg::RETRY_W-1:0];
        end
        pcrt_pkg::REG_CHECK_INTERVAL: begin
          interval_q <= pwdata[pcrt_pkg::INTERVAL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (pcrt_pkg::reg_e'(paddr[3:2]))
      pcrt_pkg::REG_TIMEOUT: begin
        prdata = pcrt_pkg::PDATA_W'(timeout_q);
      end
      pcrt_pkg::REG_MAX_RETRIES: begin
        prdata = pcrt_pkg::PDATA_W'(max_retries_q);
      end
      pcrt_pkg::REG_CHECK_INTERVAL: begin
        prdata = pcrt_pkg::PDATA_W'(interval_q);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // lowest free slot, slot 0 when full
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = 0; i < pcrt_pkg::SLOTS; i++) begin
      if (!free_found && !waiting_q[i]) begin
        free_idx   = pcrt_pkg::SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  // shared compare unit operands
  always_comb begin
    cmp_req.a   = now_q;
    cmp_req.b   = stamp_q[idx_q];
    cmp_req.lim = pcrt_pkg::TIME_W'(timeout_q);
    case (state_q)
      S_RESP: begin
        cmp_req.a   = stamp_q[idx_q];
        cmp_req.b   = best_stamp_q;
        cmp_req.lim = '0;
      end
      S_CHECK: begin
        cmp_req.b   = last_check_q;
        cmp_req.lim = pcrt_pkg::TIME_W'(interval_q);
      end
      default: begin
      end
    endcase
  end

  pcrt_cmp_unit u_cmp (
    .req_i (cmp_req),
    .rsp_o (cmp_rsp)
  );

  assign resp_match = waiting_q[idx_q] && (addr_q[idx_q] == req_peer_q)
                      && (kind_q[idx_q] == req_kind_q);
  assign resp_take  = resp_match && (!best_v_q || cmp_rsp.a_lt_b);

  assign scan_expired = waiting_q[idx_q] && !cmp_rsp.below_lim;
  assign scan_retry   = retries_q[idx_q] < max_retries_q;
  assign scan_emit    = scan_expired && (scan_retry || (kind_q[idx_q] == pcrt_pkg::KIND_PARAM));
  assign scan_step    = !(scan_emit && pend_v_q && !out_free);

  assign out_load = ((state_q == S_SCAN) && scan_step && scan_emit && pend_v_q)
                    || ((state_q == S_FLUSH) && pend_v_q && out_free);

  always_comb begin
    new_res.addr = addr_q[idx_q];
    if (scan_retry) begin
      new_res.event_res = pcrt_pkg::EVENT_RESEND;
      new_res.kind      = kind_q[idx_q];
      new_res.payload   = payload_q[idx_q];
    end else begin
      new_res.event_res = pcrt_pkg::EVENT_ABORT;
      new_res.kind      = pcrt_pkg::KIND_PARAM;
      new_res.payload   = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (pcrt_pkg::func_e'(func_i))
            pcrt_pkg::FUNC_RESP: state_d = S_RESP;
            pcrt_pkg::FUNC_TICK: state_d = S_CHECK;
            default:             state_d = S_IDLE;
          endcase
        end
      end
      S_RESP: begin
        if (idx_last) begin
          state_d = S_IDLE;
        end
      end
      S_CHECK: begin
        state_d = cmp_rsp.below_lim ? S_IDLE : S_SCAN;
      end
      S_SCAN: begin
        if (scan_step && idx_last) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_v_q || out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      now_q        <= '0;
      last_check_q <= '0;
      waiting_q    <= '0;
      idx_q        <= '0;
      best_v_q     <= 1'b0;
      pend_v_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          idx_q    <= '0;
          best_v_q <= 1'b0;
          if (in_acc) begin
            case (pcrt_pkg::func_e'(func_i))
              pcrt_pkg::FUNC_ISSUE: waiting_q[free_idx] <= 1'b1;
              pcrt_pkg::FUNC_TICK:  now_q <= now_q + 1'b1;
              default: begin
              end
            endcase
          end
        end
        S_RESP: begin
          idx_q <= idx_q + 1'b1;
          if (resp_take) begin
            best_v_q <= 1'b1;
          end
          if (idx_last) begin
            if (resp_take) begin
              waiting_q[idx_q] <= 1'b0;
            end else if (best_v_q) begin
              waiting_q[best_idx_q] <= 1'b0;
            end
          end
        end
        S_CHECK: begin
          if (!cmp_rsp.below_lim) begin
            last_check_q <= now_q;
          end
        end
        S_SCAN: begin
          if (scan_step) begin
            idx_q <= idx_q + 1'b1;
            if (scan_expired && !scan_retry) begin
              waiting_q[idx_q] <= 1'b0;
            end
            if (scan_emit) begin
              pend_v_q <= 1'b1;
            end
          end
        end
        S_FLUSH: begin
          if (pend_v_q && out_free) begin
            pend_v_q <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // slot contents and result words
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        req_peer_q <= peer_addr_i;
        req_kind_q <= cmd_kind_i;
        if (in_acc && (pcrt_pkg::func_e'(func_i) == pcrt_pkg::FUNC_ISSUE)) begin
          stamp_q[free_idx]   <= now_q;
          addr_q[free_idx]    <= peer_addr_i;
          kind_q[free_idx]    <= cmd_kind_i;
          retries_q[free_idx] <= '0;
          payload_q[free_idx] <= payload_i;
        end
      end
      S_RESP: begin
        if (resp_take) begin
          best_idx_q   <= idx_q;
          best_stamp_q <= stamp_q[idx_q];
        end
      end
      S_SCAN: begin
        if (scan_step) begin
          if (scan_expired && scan_retry) begin
            retries_q[idx_q] <= retries_q[idx_q] + 1'b1;
            stamp_q[idx_q]   <= now_q;
          end
          if (scan_emit) begin
            pend_q <= new_res;
            if (pend_v_q) begin
              out_q      <= pend_q;
              out_last_q <= 1'b0;
            end
          end
        end
      end
      S_FLUSH: begin
        if (pend_v_q && out_free) begin
          out_q      <= pend_q;
          out_last_q <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = out_q.event_res;
  assign out_addr_o    = out_q.addr;
  assign out_kind_o    = out_q.kind;
  assign out_payload_o = out_q.payload;
  assign last_o        = out_last_q;

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pend_v_q)
    else $error("pending result left behind when idle");

  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> ((state_q == S_SCAN) || (state_q == S_FLUSH)))
    else $error("pending result outside a scan");

  a_issue_sets_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (func_i == pcrt_pkg::FUNC_ISSUE)) |=> (waiting_q != '0))
    else $error("issue left no waiting slot");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import pcrt_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int PLAN_LEN = 31;
  localparam int NPHASE = 7;
  localparam int PHASE_ITEMS = 38;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 8;

  typedef struct packed {
    logic              ev;
    logic [ADDR_W-1:0] addr;
    logic              kind;
    logic [DATA_W-1:0] data;
    logic              last;
  } retry_word_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_ABORT, ROW_REG} row_e;

  typedef struct packed {
    row_e               step;
    logic [FUNC_W-1:0]  func;
    logic [ADDR_W-1:0]  addr;
    logic               kind;
    logic [DATA_W-1:0]  data;
    reg_e               reg_idx;
    logic [PDATA_W-1:0] reg_val;
    logic [ADDR_W-1:0]  abort_addr;
  } plan_row_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0]  timeout;
    logic [RETRY_W-1:0]    retries;
    logic [INTERVAL_W-1:0] every;
  } phase_cfg_t;

  typedef enum logic [1:0] {RX_OPEN, RX_EVERY_THIRD, RX_COIN, RX_LONG_HOLD} rx_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [FUNC_W-1:0]  func_i = '0;
  logic [ADDR_W-1:0]  peer_addr_i = '0;
  logic               cmd_kind_i = 1'b0;
  logic [DATA_W-1:0]  payload_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               event_res_o;
  logic [ADDR_W-1:0]  out_addr_o;
  logic               out_kind_o;
  logic [DATA_W-1:0]  out_payload_o;
  logic               last_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic [TIMEOUT_W-1:0]  lim_timeout = TIMEOUT_RST;
  logic [RETRY_W-1:0]    lim_retries = MAX_RETRIES_RST;
  logic [INTERVAL_W-1:0] scan_every = INTERVAL_RST;
  logic [TIME_W-1:0]     now_clk = '0;
  logic [TIME_W-1:0]     last_scan = '0;
  logic                  pend_busy  [SLOTS];
  logic [TIME_W-1:0]     pend_stamp [SLOTS];
  logic [ADDR_W-1:0]     pend_dest  [SLOTS];
  logic                  pend_kind  [SLOTS];
  logic [RETRY_W-1:0]    pend_tries [SLOTS];
  logic [DATA_W-1:0]     pend_data  [SLOTS];

  retry_word_t tick_words[$];
  retry_word_t pending_retry_words[$];
  int unsigned mismatch_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned pattern_cnt = 0;
  rx_mode_e    rx_mode = RX_OPEN;

  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_QUIET,   FUNC_UNUSED, 4'hF, 1'b1, {DATA_W{1'b1}}, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_QUIET,   FUNC_RESP,   4'h5, 1'b0, 64'h0, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_PREDICT, FUNC_ISSUE,  4'hF, 1'b1, {DATA_W{1'b1}}, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_PREDICT, FUNC_ISSUE,  4'h0, 1'b0, 64'h0, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_PREDICT, FUNC_ISSUE,  4'h0, 1'b0, 64'h0123_4567_89AB_CDEF, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_PREDICT, FUNC_RESP,   4'h0, 1'b0, 64'h0, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_QUIET,   FUNC_TICK,   4'h0, 1'b0, 64'h0, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_REG,     FUNC_TICK,   4'h0, 1'b0, 64'h0, REG_TIMEOUT, 32'd2, 4'h0},
    '{ROW_REG,     FUNC_TICK,   4'h0, 1'b0, 64'h0, REG_MAX_RETRIES, 32'd1, 4'h0},
    '{ROW_REG,     FUNC_TICK,   4'h0, 1'b0, 64'h0, REG_CHECK_INTERVAL, 32'd1, 4'h0},
    '{ROW_PREDICT, FUNC_TICK,   4'h0, 1'b0, 64'h0, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_PREDICT, FUNC_TICK,   4'h0, 1'b0, 64'h0, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_ABORT,   FUNC_TICK,   4'h0, 1'b0, 64'h0, REG_TIMEOUT, 32'd0, 4'hF},
    '{ROW_REG,     FUNC_TICK,   4'h0, 1'b0, 64'h0, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_REG,     FUNC_TICK,   4'h0, 1'b0, 64'h0, REG_MAX_RETRIES, 32'd0, 4'h0},
    '{ROW_REG,     FUNC_TICK,   4'h0, 1'b0, 64'h0, REG_CHECK_INTERVAL, 32'd0, 4'h0},
    '{ROW_PREDICT, FUNC_ISSUE,  4'h7, 1'b1, 64'hA5A5_A5A5_A5A5_A5A5, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_ABORT,   FUNC_TICK,   4'h0, 1'b0, 64'h0, REG_TIMEOUT, 32'd0, 4'h7},
    '{ROW_REG,     FUNC_TICK,   4'h0, 1'b0, 64'h0, REG_MAX_RETRIES, 32'd255, 4'h0},
    '{ROW_PREDICT, FUNC_ISSUE,  4'h1, 1'b1, 64'h1111_0000_0000_0001, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_PREDICT, FUNC_ISSUE,  4'h2, 1'b0, 64'h2222_0000_0000_0002, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_PREDICT, FUNC_ISSUE,  4'h3, 1'b1, 64'h3333_0000_0000_0003, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_PREDICT, FUNC_ISSUE,  4'h4, 1'b0, 64'h4444_0000_0000_0004, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_PREDICT, FUNC_ISSUE,  4'h5, 1'b1, 64'h5555_0000_0000_0005, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_PREDICT, FUNC_ISSUE,  4'h6, 1'b0, 64'h6666_0000_0000_0006, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_PREDICT, FUNC_ISSUE,  4'h7, 1'b1, 64'h7777_0000_0000_0007, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_PREDICT, FUNC_ISSUE,  4'h8, 1'b0, 64'h8888_0000_0000_0008, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_PREDICT, FUNC_ISSUE,  4'h9, 1'b0, 64'h5555_5555_5555_5555, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_PREDICT, FUNC_TICK,   4'h0, 1'b0, 64'h0, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_PREDICT, FUNC_RESP,   4'h9, 1'b0, 64'h0, REG_TIMEOUT, 32'd0, 4'h0},
    '{ROW_PREDICT, FUNC_TICK,   4'h0, 1'b0, 64'h0, REG_TIMEOUT, 32'd0, 4'h0}
  };

  phase_cfg_t phases [NPHASE] = '{
    '{16'd5,     8'd2,   10'd1},
    '{16'd1,     8'd0,   10'd1},
    '{16'd65535, 8'd3,   10'd1000},
    '{16'd3,     8'd255, 10'd2},
    '{16'd0,     8'd1,   10'd0},
    '{16'd100,   8'd3,   10'd10},
    '{16'd4,     8'd2,   10'd1}
  };

  pending_command_retry_tracker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .peer_addr_i   (peer_addr_i),
    .cmd_kind_i    (cmd_kind_i),
    .payload_i     (payload_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_res_o   (event_res_o),
    .out_addr_o    (out_addr_o),
    .out_kind_o    (out_kind_o),
    .out_payload_o (out_payload_o),
    .last_o        (last_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  function automatic void track_command_event(input logic [FUNC_W-1:0] f,
                                              input logic [ADDR_W-1:0] a,
                                              input logic k,
                                              input logic [DATA_W-1:0] d);
    int i;
    int best;
    logic [TIME_W-1:0] age;
    tick_words.delete();
    case (f)
      FUNC_ISSUE: begin
        best = 0;
        for (i = SLOTS - 1; i >= 0; i--) begin
          if (!pend_busy[i]) best = i;
        end
        pend_busy[best]  = 1'b1;
        pend_stamp[best] = now_clk;
        pend_dest[best]  = a;
        pend_kind[best]  = k;
        pend_tries[best] = '0;
        pend_data[best]  = d;
      end
      FUNC_RESP: begin
        best = -1;
        for (i = 0; i < SLOTS; i++) begin
          if (pend_busy[i] && pend_dest[i] == a && pend_kind[i] == k) begin
            if (best < 0 || pend_stamp[i] < pend_stamp[best]) best = i;
          end
        end
        if (best >= 0) begin
          pend_busy[best]  = 1'b0;
          pend_stamp[best] = '0;
          pend_dest[best]  = '0;
          pend_kind[best]  = 1'b0;
          pend_tries[best] = '0;
          pend_data[best]  = '0;
        end
      end
      FUNC_TICK: begin
        now_clk = now_clk + 1'b1;
        if (now_clk - last_scan >= TIME_W'(scan_every)) begin
          last_scan = now_clk;
          for (i = 0; i < SLOTS; i++) begin
            age = now_clk - pend_stamp[i];
            if (pend_busy[i] && age >= TIME_W'(lim_timeout)) begin
              pend_busy[i]  = 1'b0;
              pend_stamp[i] = '0;
              if (pend_tries[i] < lim_retries) begin
                pend_tries[i] = pend_tries[i] + 1'b1;
                pend_busy[i]  = 1'b1;
                pend_stamp[i] = now_clk;
                tick_words.push_back(retry_word_t'{EVENT_RESEND, pend_dest[i], pend_kind[i],
                                                   pend_data[i], 1'b0});
              end else if (pend_kind[i] == KIND_PARAM) begin
                tick_words.push_back(retry_word_t'{EVENT_ABORT, pend_dest[i], KIND_PARAM,
                                                   {DATA_W{1'b0}}, 1'b0});
              end
            end
          end
          if (tick_words.size() != 0) tick_words[tick_words.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
                           input logic k, input logic [DATA_W-1:0] d);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    peer_addr_i <= a;
    cmd_kind_i  <= k;
    payload_i   <= d;
    // hold the word until the block takes it
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic drive_and_predict(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
                                   input logic k, input logic [DATA_W-1:0] d);
    send_word(f, a, k, d);
    track_command_event(f, a, k, d);
    foreach (tick_words[n]) begin
      pending_retry_words.push_back(tick_words[n]);
    end
  endtask

  task automatic send_random_word(output bit counted);
    int unsigned pick;
    int unsigned slot;
    int unsigned busy_idx[$];
    logic [FUNC_W-1:0] f;
    logic [ADDR_W-1:0] a;
    logic k;
    logic [DATA_W-1:0] d;
    pick = $urandom_range(0, 99);
    a = ADDR_W'($urandom_range(0, 15));
    k = 1'($urandom_range(0, 1));
    d = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: d = {DATA_W{1'b0}};
      1: d = {DATA_W{1'b1}};
      default: ;
    endcase
    if (pick < 5) begin
      f = FUNC_UNUSED;
    end else if (pick < 40) begin
      f = FUNC_ISSUE;
    end else if (pick < 62) begin
      f = FUNC_RESP;
      foreach (pend_busy[i]) begin
        if (pend_busy[i]) busy_idx.push_back(i);
      end
      if (busy_idx.size() != 0 && $urandom_range(0, 4) != 0) begin
        slot = busy_idx[$urandom_range(0, busy_idx.size() - 1)];
        a = pend_dest[slot];
        k = pend_kind[slot];
      end
    end else begin
      f = FUNC_TICK;
    end
    drive_and_predict(f, a, k, d);
    counted = (f != FUNC_UNUSED);
  endtask

  task automatic write_reg(input reg_e r, input logic [PDATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({r, 2'b00});
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_TIMEOUT:        lim_timeout = v[TIMEOUT_W-1:0];
      REG_MAX_RETRIES:    lim_retries = v[RETRY_W-1:0];
      REG_CHECK_INTERVAL: scan_every  = v[INTERVAL_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_retry_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_watch
    retry_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_retry_words.size() == 0) begin
        $display("%0t: unexpected word event %0d addr %0h kind %0d payload %h last %0d",
                 $time, event_res_o, out_addr_o, out_kind_o, out_payload_o, last_o);
        mismatch_cnt++;
      end else begin
        want = pending_retry_words.pop_front();
        if (event_res_o !== want.ev) begin
          $display("%0t: event_res expected %0d got %0d", $time, want.ev, event_res_o);
          mismatch_cnt++;
        end
        if (out_addr_o !== want.addr) begin
          $display("%0t: out_addr expected %0h got %0h", $time, want.addr, out_addr_o);
          mismatch_cnt++;
        end
        if (out_kind_o !== want.kind) begin
          $display("%0t: out_kind expected %0d got %0d", $time, want.kind, out_kind_o);
          mismatch_cnt++;
        end
        if (out_payload_o !== want.data) begin
          $display("%0t: out_payload expected %h got %h", $time, want.data, out_payload_o);
          mismatch_cnt++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %0d got %0d", $time, want.last, last_o);
          mismatch_cnt++;
        end
      end
    end
    pattern_cnt++;
    if (pattern_cnt % 64 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:        out_ready_i <= 1'b1;
      RX_EVERY_THIRD: out_ready_i <= (pattern_cnt % 3) != 0;
      RX_COIN:        out_ready_i <= 1'($urandom_range(0, 1));
      default:        out_ready_i <= (pattern_cnt % 12) >= 10;
    endcase
  end

  initial begin
    #500000;
    $display("pending_command_retry_tracker regression: fail");
    $finish;
  end

  initial begin
    int unsigned sent;
    bit counted;
    foreach (pend_busy[i]) begin
      pend_busy[i]  = 1'b0;
      pend_stamp[i] = '0;
      pend_dest[i]  = '0;
      pend_kind[i]  = 1'b0;
      pend_tries[i] = '0;
      pend_data[i]  = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      if (plan[r].step == ROW_REG) begin
        wait_idle();
        write_reg(plan[r].reg_idx, plan[r].reg_val);
      end else if (plan[r].step == ROW_PREDICT) begin
        drive_and_predict(plan[r].func, plan[r].addr, plan[r].kind, plan[r].data);
      end else begin
        send_word(plan[r].func, plan[r].addr, plan[r].kind, plan[r].data);
        track_command_event(plan[r].func, plan[r].addr, plan[r].kind, plan[r].data);
        if (plan[r].step == ROW_ABORT) begin
          pending_retry_words.push_back(retry_word_t'{EVENT_ABORT, plan[r].abort_addr,
                                                      KIND_PARAM, {DATA_W{1'b0}}, 1'b1});
        end
      end
    end

    foreach (phases[p]) begin
      wait_idle();
      write_reg(REG_TIMEOUT, PDATA_W'(phases[p].timeout));
      write_reg(REG_MAX_RETRIES, PDATA_W'(phases[p].retries));
      write_reg(REG_CHECK_INTERVAL, PDATA_W'(phases[p].every));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_random_word(counted);
        if (counted) sent++;
      end
    end

    wait_idle();
    if (mismatch_cnt == 0 && pending_retry_words.size() == 0) begin
      $display("pending_command_retry_tracker regression: pass");
    end else begin
      $display("pending_command_retry_tracker regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/pcrt_pkg.sv
sv/pcrt_cmp_unit.sv
sv/pending_command_retry_tracker.sv
bench/tb_top.sv
